FILE: rtl/core/fir9tb_pkg.sv
`default_nettype none
package fir9tb_pkg;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int W_BITS     = 12;
    localparam int THR_W      = 8;
    localparam int WLO_W      = 60;
    localparam int WHI_W      = 48;
    localparam int WALL_W     = WLO_W + WHI_W;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 2;
    localparam int FIELD_W    = 12;

    // datapath widths: signed q4.8 weight times unsigned pixel, nine of them summed
    localparam int PROD_W     = 20;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 4;

    // parameter defaults
    localparam int TAPS_DEF   = 9;
    localparam int COORD_DEF  = 12;

    // reset values
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH = 2'd2;

    // per-cell controls
    typedef struct packed {
        logic shift;    // window moves one place toward the oldest end
        logic capture;  // product register loads
    } t_cell_ctl;

    // tap k weight out of the packed weight registers
    function automatic logic signed [W_BITS-1:0] tap_weight(
        input logic [WALL_W-1:0] w,
        input int                k
    );
        return w[W_BITS*k +: W_BITS];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fir9_threshold_binarizer.sv
`default_nettype none
// nine-tap fir over a pixel stream, thresholded to one bit. every accepted item shifts
// its pixel into a row of cells (oldest at tap 0); once TAPS items have arrived each new
// item gives one result: the sum of weight times pixel over the window, compared against
// threshold*256, tagged with the row/column of the window's centre pixel. weights are
// signed q4.8 packed in weights_low (taps 0-4) and weights_high (taps 5-8); the sum is
// exact. one item per clock is sustained while the output is not stalled. the pipeline
// has four registers (window cells, per-cell product, group sums, compare/output); each
// stage moves when the one after it is empty or moving, so bubbles close up and input
// fills empty stages while a result waits on a stalled output. configuration must be
// written by the user only while no item is in flight; the block does not enforce it.
module fir9_threshold_binarizer
    import fir9tb_pkg::*;
#(
    parameter int TAPS       = TAPS_DEF,
    parameter int COORD_BITS = COORD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel items in
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic [FIELD_W-1:0]    i_pixel_row,
    input  wire logic [FIELD_W-1:0]    i_pixel_col,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    // result items out
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic [FIELD_W-1:0]    o_out_row,
    output      logic [FIELD_W-1:0]    o_out_col,
    output      logic                  o_out_bit
);

    localparam int CENTRE = TAPS / 2;
    localparam int CDEPTH = TAPS - CENTRE;
    localparam int NGRP   = (TAPS + 2) / 3;

    // ---------------- configuration registers ----------------
    logic [THR_W-1:0] r_thr;
    logic [WLO_W-1:0] r_wlo;
    logic [WHI_W-1:0] r_whi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_wlo <= '0;
            r_whi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD:    r_thr <= i_cfg_data[THR_W-1:0];
                CFG_WEIGHTS_LOW:  r_wlo <= i_cfg_data[WLO_W-1:0];
                CFG_WEIGHTS_HIGH: r_whi <= i_cfg_data[WHI_W-1:0];
                default:          ; // unused index, write dropped
            endcase
        end
    end

    logic [WALL_W-1:0] w_all;
    assign w_all = {r_whi, r_wlo};

    // ---------------- stage valids and enables ----------------
    // a: window holds a completed window, b: products, c: group sums, d: output register
    logic r_va, r_vb, r_vc, r_ov;
    logic en_a, en_b, en_c, en_d;
    logic in_acc;

    assign en_d   = !r_ov || !i_stall;
    assign en_c   = !r_vc || en_d;
    assign en_b   = !r_vb || en_c;
    assign en_a   = !r_va || en_b;
    assign o_stall = !en_a;
    assign in_acc = i_valid && en_a;

    // fill count saturates at TAPS; a result is due once this item makes it TAPS
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             filled_now;

    assign filled_now = (r_fill >= CNT_W'(TAPS - 1));
    assign n_fill     = filled_now ? CNT_W'(TAPS) : r_fill + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill <= n_fill;
            end
            if (en_a) begin
                r_va <= in_acc && filled_now;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_ov <= r_vc;
            end
        end
    end

    // ---------------- window: row of cells ----------------
    t_cell_ctl               cell_ctl;
    logic [PIX_W-1:0]        cell_val  [TAPS];
    logic signed [PROD_W-1:0] cell_prod [TAPS];

    assign cell_ctl.shift   = in_acc;
    assign cell_ctl.capture = en_b;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic [PIX_W-1:0] feed;
        // newest pixel enters at the top tap, each cell hands its value one place down
        if (k == TAPS - 1) begin : g_top
            assign feed = i_pixel_value;
        end else begin : g_mid
            assign feed = cell_val[k + 1];
        end
        fir9tb_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_value  (feed),
            .i_weight (tap_weight(w_all, k)),
            .o_value  (cell_val[k]),
            .o_prod   (cell_prod[k])
        );
    end

    // ---------------- centre coordinates shift line ----------------
    logic [COORD_BITS+FIELD_W-1:0] row_wide_in, col_wide_in;
    logic [COORD_BITS-1:0]         r_crow [CDEPTH];
    logic [COORD_BITS-1:0]         r_ccol [CDEPTH];

    // keep the low COORD_BITS of the incoming coordinate
    assign row_wide_in = {{COORD_BITS{1'b0}}, i_pixel_row};
    assign col_wide_in = {{COORD_BITS{1'b0}}, i_pixel_col};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < CDEPTH - 1; j++) begin
                r_crow[j] <= r_crow[j + 1];
                r_ccol[j] <= r_ccol[j + 1];
            end
            r_crow[CDEPTH-1] <= row_wide_in[COORD_BITS-1:0];
            r_ccol[CDEPTH-1] <= col_wide_in[COORD_BITS-1:0];
        end
    end

    // coordinates ride along with the sum pipeline
    logic [COORD_BITS-1:0] r_row_b, r_col_b, r_row_c, r_col_c;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_row_b <= r_crow[0];
            r_col_b <= r_ccol[0];
        end
        if (en_c) begin
            r_row_c <= r_row_b;
            r_col_c <= r_col_b;
        end
    end

    // ---------------- group sums ----------------
    logic signed [SUM_W-1:0] grp [NGRP];

    fir9tb_adder #(
        .TAPS (TAPS)
    ) u_adder (
        .i_clk  (i_clk),
        .i_en   (en_c),
        .i_prod (cell_prod),
        .o_grp  (grp)
    );

    // ---------------- final sum, compare, output register ----------------
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] thr_scaled;

    always_comb begin
        total = '0;
        for (int g = 0; g < NGRP; g++) begin
            total = total + grp[g];
        end
    end

    // threshold in the same q.8 scale as the sum
    assign thr_scaled = $signed({{(SUM_W - THR_W - 8){1'b0}}, r_thr, 8'h00});

    logic [COORD_BITS+FIELD_W-1:0] row_wide_out, col_wide_out;
    logic [FIELD_W-1:0]            r_out_row, r_out_col;
    logic                          r_out_bit;

    assign row_wide_out = {{FIELD_W{1'b0}}, r_row_c};
    assign col_wide_out = {{FIELD_W{1'b0}}, r_col_c};

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_out_row <= row_wide_out[FIELD_W-1:0];
            r_out_col <= col_wide_out[FIELD_W-1:0];
            r_out_bit <= (total >= thr_scaled);
        end
    end

    assign o_valid   = r_ov;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_out_bit = r_out_bit;

`ifndef SYNTHESIS
    // stalling the input only happens with every stage holding a result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_va && r_vb && r_vc && r_ov))
        else $error("input stalled with a free pipeline stage");

    // no result is started while the window is still filling
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !filled_now) |=> !r_va)
        else $error("result started before window filled");

    // a pending window result is kept until the product stage takes it
    a_keep_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_va && !en_b) |=> r_va)
        else $error("window result dropped");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/fir9tb_cell.sv
`default_nettype none
module fir9tb_cell
    import fir9tb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [PIX_W-1:0]         i_value,
    input  wire logic signed [W_BITS-1:0] i_weight,
    output      logic [PIX_W-1:0]         o_value,
    output      logic signed [PROD_W-1:0] o_prod
);

    logic [PIX_W-1:0]           r_value;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [W_BITS+PIX_W:0] n_prod;

    // pixel is unsigned, widened with a zero sign bit
    assign n_prod = i_weight * $signed({1'b0, r_value});

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_value;
        end
        if (i_ctl.capture) begin
            r_prod <= n_prod[PROD_W-1:0];
        end
    end

    assign o_value = r_value;
    assign o_prod  = r_prod;

endmodule
`default_nettype wire

FILE: rtl/core/fir9tb_adder.sv
`default_nettype none
module fir9tb_adder
    import fir9tb_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [PROD_W-1:0] i_prod [TAPS],
    output      logic signed [SUM_W-1:0]  o_grp  [(TAPS + 2) / 3]
);

    localparam int NGRP = (TAPS + 2) / 3;

    logic signed [SUM_W-1:0] r_grp [NGRP];
    logic signed [SUM_W-1:0] n_grp [NGRP];

    // groups of three products each, the last group short when TAPS is not a multiple of three
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < 3; j++) begin
                if (3 * g + j < TAPS) begin
                    n_grp[g] = n_grp[g] + SUM_W'(i_prod[3 * g + j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp = r_grp;

endmodule
`default_nettype wire
